### rtl/core/fvmet_pkg.sv
`timescale 1ns / 1ps
package fvmet_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 24;
  localparam int unsigned GRAD_FRAC_BITS_DEF = 16;
  localparam int unsigned TOL_W              = 50;
  localparam int unsigned CONV_W             = 25;
  localparam int unsigned GRAD_W             = 32;

  localparam logic [0:0] OP_E2M = 1'b0;
  localparam logic [0:0] OP_M2E = 1'b1;

endpackage

### rtl/core/fvmet_core.sv
`timescale 1ns / 1ps
// Pipelined datapath: squares, square root by one result bit a stage,
// then gradient quotients by one quotient bit a stage.
module fvmet_core #(
  parameter int unsigned CB = fvmet_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned FB = fvmet_pkg::GRAD_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_v,
  input  logic                            op,
  input  logic signed [CB-1:0]            px,
  input  logic signed [CB-1:0]            py,
  input  logic signed [CB-1:0]            pz,
  input  logic [CB-1:0]                   w,
  input  logic [fvmet_pkg::TOL_W-1:0]     tol,
  output logic                            out_v,
  output logic [fvmet_pkg::CONV_W-1:0]    conv,
  output logic signed [fvmet_pkg::GRAD_W-1:0] gx,
  output logic signed [fvmet_pkg::GRAD_W-1:0] gy,
  output logic signed [fvmet_pkg::GRAD_W-1:0] gz,
  output logic signed [fvmet_pkg::GRAD_W-1:0] gw,
  output logic                            flag
);
  localparam int unsigned SW   = 2*CB + 2;          // sum of squares width
  localparam int unsigned RW   = CB + 1;            // root width
  localparam int unsigned RS   = RW;                // root stages
  localparam int unsigned QB   = 32;                // quotient bits incl round bit
  localparam int unsigned NW   = CB + FB + 1 + QB;  // numerator shift register
  localparam int unsigned PW   = 2*NW;              // quotient compare width
  localparam int unsigned TW   = QB + SW;           // running t*S width
  localparam int unsigned GW   = fvmet_pkg::GRAD_W;
  localparam int unsigned CW   = fvmet_pkg::CONV_W;
  localparam int unsigned CMPW = (SW > fvmet_pkg::TOL_W) ? SW : fvmet_pkg::TOL_W;

  // Stage 0: magnitudes and squares
  logic              v0;
  logic              op0;
  logic [CB-1:0]     m0 [4];
  logic [3:0]        n0;
  logic [2*CB-1:0]   sq0 [4];
  logic [fvmet_pkg::TOL_W-1:0] tol0;

  function automatic logic [CB-1:0] mag_of(input logic [CB-1:0] x);
    mag_of = x[CB-1] ? (~x + {{(CB-1){1'b0}}, 1'b1}) : x;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op0   <= op;
      m0[0] <= mag_of(px);
      m0[1] <= mag_of(py);
      m0[2] <= mag_of(pz);
      m0[3] <= w;
      n0    <= {1'b0, pz[CB-1] ^ ~op, py[CB-1] ^ ~op, px[CB-1] ^ ~op};
      sq0[0] <= mag_of(px) * mag_of(px);
      sq0[1] <= mag_of(py) * mag_of(py);
      sq0[2] <= mag_of(pz) * mag_of(pz);
      sq0[3] <= w * w;
      tol0  <= tol;
    end
  end

  // Stage 1: S, sign and tolerance compares
  logic              v1;
  logic [SW-1:0]     s1;
  logic              cz1, fl1;
  logic [CB-1:0]     m1 [4];
  logic [3:0]        n1;
  logic [SW-1:0]     p2, w2, diff, sum;
  logic [CMPW-1:0]   tolx, diffx, sumx;
  logic              pos;
  always_comb begin
    p2    = SW'(sq0[0]) + SW'(sq0[1]) + SW'(sq0[2]);
    w2    = SW'(sq0[3]);
    pos   = w2 > p2;
    diff  = w2 - p2;
    sum   = w2 + p2;
    tolx  = CMPW'(tol0);
    diffx = CMPW'(diff);
    sumx  = CMPW'(sum);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= m0;
      n1 <= n0;
      if (op0 == fvmet_pkg::OP_E2M) begin
        s1  <= pos ? diff : '0;
        cz1 <= !(pos && diffx >= tolx);
        fl1 <= !(pos && diffx > tolx);
      end else begin
        s1  <= sum;
        cz1 <= 1'b0;
        fl1 <= !(sumx > tolx);
      end
    end
  end

  // Root pipeline: non-restoring-free bitwise root, one bit a stage.
  // Keeps remainder rem = S - r^2 to avoid squaring.
  logic          rv  [RS+1];
  logic [SW-1:0] rs  [RS+1];
  logic [SW:0]   rrm [RS+1];
  logic [RW-1:0] rr  [RS+1];
  logic          rcz [RS+1], rfl [RS+1];
  logic [CB-1:0] rm  [RS+1][4];
  logic [3:0]    rn  [RS+1];
  always_comb begin
    rv[0] = v1; rs[0] = s1; rrm[0] = {1'b0, s1}; rr[0] = '0;
    rcz[0] = cz1; rfl[0] = fl1; rm[0] = m1; rn[0] = n1;
  end
  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam int unsigned BIT = RS - 1 - k;
    logic [SW+1:0] trial;
    logic          take;
    always_comb begin
      // (r + b)^2 - r^2 = 2rb + b^2
      trial = ((SW+2)'(rr[k]) << (BIT + 1)) + ((SW+2)'(1) << (2*BIT));
      take  = trial <= (SW+2)'(rrm[k]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (adv) begin
        rv[k+1] <= rv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rs[k+1]  <= rs[k];
        rrm[k+1] <= take ? rrm[k] - trial[SW:0] : rrm[k];
        rr[k+1]  <= take ? (rr[k] | (RW'(1) << BIT)) : rr[k];
        rcz[k+1] <= rcz[k];
        rfl[k+1] <= rfl[k];
        rm[k+1]  <= rm[k];
        rn[k+1]  <= rn[k];
      end
    end
  end

  // Rounding of the root, and set up of divisions.
  // grad = mag*2^F/sqrt(S); compute q = floor(mag*2^(F+1)/sqrt(S)) exactly
  // via t = floor(sqrt(mag^2*2^(2F+2)/S)) = floor(mag*2^(F+1)/len).
  // Done as long division of mag*2^(F+1)*len by S.
  logic          dv;
  logic [CW-1:0] dconv;
  logic          dfl;
  logic [3:0]    dn;
  logic [SW-1:0] ds;
  logic [RW-1:0] rtf;
  logic          rup;
  always_comb begin
    rtf = rr[RS];
    rup = rrm[RS] > (SW+1)'(rtf);
  end
  // numerators: mag * 2^(F+1) * len. len irrational, so use root-free form:
  // t^2*S <= mag^2*2^(2F+2). Quotient by bit with running squares.
  logic [2*CB-1:0] msq [4];
  logic [PW-1:0]   qrhs0 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      msq[i] = rm[RS][i] * rm[RS][i];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (adv) begin
      dv <= rv[RS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (rcz[RS]) begin
        dconv <= '0;
      end else if ((RW+1)'(rtf) + (RW+1)'(rup) > (RW+1)'({CW{1'b1}})) begin
        dconv <= '1;
      end else begin
        dconv <= CW'(rtf + RW'(rup));
      end
      dfl <= rfl[RS];
      dn  <= rn[RS];
      ds  <= rs[RS];
      for (int i = 0; i < 4; i++) begin
        qrhs0[i] <= PW'(msq[i]) << (2*FB + 2);
      end
    end
  end

  // Quotient pipeline: per bit, keep t, t*S and t^2*S, compare with rhs.
  // (t+b)^2 S = t^2 S + 2 b (t S) + b^2 S, shift-add only.
  logic          qv  [QB+1];
  logic [CW-1:0] qc  [QB+1];
  logic          qf  [QB+1];
  logic [3:0]    qn  [QB+1];
  logic [SW-1:0] qs  [QB+1];
  logic [PW-1:0] qr  [QB+1][4];
  logic [QB-1:0] qt  [QB+1][4];
  logic [TW-1:0] qts [QB+1][4];
  logic [PW-1:0] qp  [QB+1][4];
  always_comb begin
    qv[0] = dv; qc[0] = dconv; qf[0] = dfl; qn[0] = dn; qs[0] = ds;
    for (int i = 0; i < 4; i++) begin
      qr[0][i] = qrhs0[i]; qt[0][i] = '0; qts[0][i] = '0; qp[0][i] = '0;
    end
  end
  for (genvar k = 0; k < QB; k++) begin : g_quo
    localparam int unsigned BIT = QB - 1 - k;
    logic [PW+1:0] cand [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        cand[i] = (PW+2)'(qp[k][i])
                + ((PW+2)'(qts[k][i]) << (BIT + 1))
                + ((PW+2)'(qs[k]) << (2*BIT));
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (adv) begin
        qv[k+1] <= qv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qc[k+1] <= qc[k];
        qf[k+1] <= qf[k];
        qn[k+1] <= qn[k];
        qs[k+1] <= qs[k];
        for (int i = 0; i < 4; i++) begin
          qr[k+1][i] <= qr[k][i];
          if (cand[i] <= (PW+2)'(qr[k][i])) begin
            qt[k+1][i]  <= qt[k][i] | (QB'(1) << BIT);
            qts[k+1][i] <= qts[k][i] + (TW'(qs[k]) << BIT);
            qp[k+1][i]  <= cand[i][PW-1:0];
          end else begin
            qt[k+1][i]  <= qt[k][i];
            qts[k+1][i] <= qts[k][i];
            qp[k+1][i]  <= qp[k][i];
          end
        end
      end
    end
  end

  // Output stage: round, sign, saturate positive results; zero all gradients when flagged.
  function automatic logic [GW-1:0] fin(input logic [QB-1:0] t, input logic ng);
    logic [QB:0] q;
    q = ({1'b0, t} + (QB+1)'(1)) >> 1;
    if (ng) fin = GW'(~q + (QB+1)'(1));
    else if (q > (QB+1)'(32'h7FFF_FFFF)) fin = 32'h7FFF_FFFF;
    else fin = GW'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= qv[QB];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      conv <= qc[QB];
      flag <= qf[QB];
      gx   <= qf[QB] ? '0 : fin(qt[QB][0], qn[QB][0]);
      gy   <= qf[QB] ? '0 : fin(qt[QB][1], qn[QB][1]);
      gz   <= qf[QB] ? '0 : fin(qt[QB][2], qn[QB][2]);
      gw   <= qf[QB] ? '0 : fin(qt[QB][3], 1'b0);
    end
  end
endmodule

### rtl/core/four_vector_mass_energy_transform_top.sv
`timescale 1ns / 1ps
// Four-vector mass / energy transform.
// Input channel in_valid/in_ready carries op, px, py, pz, fourth_coord.
// op 0: fourth_coord is energy; gives mass and mass gradient.
// op 1: fourth_coord is mass; gives energy and energy gradient.
// Output channel out_valid/out_ready carries converted, grad_x..grad_w
// (Q16.16) and below_tolerance.
// Config channel cfg_valid/cfg_ready writes mass_tolerance; write only when
// idle. Reset clears the tolerance to zero.
// Throughput: one transaction per cycle while the output is not stalled. The
// pipeline is two stages for squares and S, one stage per root bit (CB+1),
// a rounding stage, one stage per gradient quotient bit (32) and an output
// register.
// When the receiver stalls the whole pipeline holds; in_ready follows
// out_ready or an empty output register, so nothing is lost.
// Reset empties the pipeline.
module four_vector_mass_energy_transform_top #(
  parameter int unsigned COMPONENT_BITS = fvmet_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned GRAD_FRAC_BITS = fvmet_pkg::GRAD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fvmet_pkg::TOL_W-1:0]         mass_tolerance,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [COMPONENT_BITS-1:0]    px,
  input  logic signed [COMPONENT_BITS-1:0]    py,
  input  logic signed [COMPONENT_BITS-1:0]    pz,
  input  logic [COMPONENT_BITS-1:0]           fourth_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fvmet_pkg::CONV_W-1:0]        converted,
  output logic signed [fvmet_pkg::GRAD_W-1:0] grad_x,
  output logic signed [fvmet_pkg::GRAD_W-1:0] grad_y,
  output logic signed [fvmet_pkg::GRAD_W-1:0] grad_z,
  output logic signed [fvmet_pkg::GRAD_W-1:0] grad_w,
  output logic                                below_tolerance
);
  logic [fvmet_pkg::TOL_W-1:0] tol;
  logic adv;

  // Tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid) begin
      tol <= mass_tolerance;
    end
  end

  // Pipeline advances unless a finished result is held
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  fvmet_core #(.CB(COMPONENT_BITS), .FB(GRAD_FRAC_BITS)) u_core (
    .clk(clk), .rst(rst), .adv(adv), .in_v(in_valid), .op(op),
    .px(px), .py(py), .pz(pz), .w(fourth_coord), .tol(tol),
    .out_v(out_valid), .conv(converted), .gx(grad_x), .gy(grad_y),
    .gz(grad_z), .gw(grad_w), .flag(below_tolerance)
  );
endmodule

### rtl/core/fvmet_checker.sv
`timescale 1ns / 1ps
module fvmet_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        below_tolerance,
  input logic [31:0] grad_x,
  input logic [31:0] grad_w
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ready && out_valid |-> !in_ready) else $error("accept while full");
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && below_tolerance |-> grad_x == 32'd0 && grad_w == 32'd0)
    else $error("gradient not zeroed");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind four_vector_mass_energy_transform_top fvmet_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .below_tolerance(below_tolerance),
  .grad_x(grad_x), .grad_w(grad_w)
);
